/* rtl/npc_pkg.sv */
// Package for the nearest palette color block.
// Holds sizes, item structs, operation codes and the search state type.
// No dependencies.
package npc_pkg;

  localparam int NUM_COLORS = 16;
  localparam int PAL_AW     = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
  // nearest_index carries 4 bits, so at most 16 entries take part
  localparam int SEARCH_MAX = (NUM_COLORS < 16) ? NUM_COLORS : 16;

  localparam int CH_W   = 8;
  localparam int IDX_W  = 4;
  localparam int DIST_W = 18;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] COLORS_IN_USE_RESET = CFG_W'(16);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_WRITE    = 1'b0,
    CMD_CLASSIFY = 1'b1
  } npc_cmd_e;

  typedef enum logic {
    OP_WRITE,
    OP_CLASSIFY
  } npc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } npc_state_e;

  typedef struct packed {
    logic [0:0]       command;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } npc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_squared_distance;
  } npc_out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } npc_rgb_t;

  // Decoded item passed from the front queue to the search engine
  typedef struct packed {
    npc_op_e           op;
    logic [PAL_AW-1:0] slot;
    npc_rgb_t          rgb;
  } npc_job_t;

  // Queue-to-engine handshake
  typedef struct packed {
    logic     valid;
    npc_job_t job;
  } npc_jobq_t;

endpackage

/* rtl/nearest_palette_color.sv */
// Top level of the nearest palette color classifier.
// Joins npc_front (decode and job queue) and npc_back (palette and search).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o | npc_in_t in_i
//   out     | output    | out_valid_o / out_stall_i | npc_out_t out_o
//   cfg     | input     | cfg_we_i               | cfg_data_i (colors_in_use)
//
// A write item updates the palette as the engine takes it from the queue; a
// classify item scans colors_in_use entries clamped to 1..16, one per cycle.
// The two-entry job queue keeps taking items while the engine searches, until full.
// Reset clears the palette to zero and sets colors_in_use to 16.
// A stalled result waits in the output register; the engine then holds its
// finished result until the register drains.
module nearest_palette_color (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  npc_pkg::npc_in_t          in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output npc_pkg::npc_out_t         out_o,
  input  logic                      cfg_we_i,
  input  logic [npc_pkg::CFG_W-1:0] cfg_data_i
);

  npc_pkg::npc_jobq_t jobq;
  logic               job_pop;

  npc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .jobq_o     (jobq),
    .job_pop_i  (job_pop)
  );

  npc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .jobq_i      (jobq),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

/* rtl/npc_front.sv */
// Front end: accepts input items, decodes them into jobs and queues them.
// Uses npc_pkg for the item and job types.
module npc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  npc_pkg::npc_in_t   in_i,
  output npc_pkg::npc_jobq_t jobq_o,
  input  logic               job_pop_i
);

  localparam int CNT_W = $clog2(npc_pkg::QUEUE_DEPTH + 1);

  npc_pkg::npc_job_t               fifo_q [npc_pkg::QUEUE_DEPTH];
  logic [npc_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [npc_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]                count_q, count_d;
  npc_pkg::npc_job_t               job;
  logic                            accept;
  logic                            in_range;
  logic                            push;
  logic                            pop;

  assign in_stall_o = (count_q == CNT_W'(npc_pkg::QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // Decode; a write beyond the palette is taken and dropped
  always_comb begin
    in_range = int'(in_i.entry_index) < npc_pkg::NUM_COLORS;
    job.op   = (npc_pkg::npc_cmd_e'(in_i.command) == npc_pkg::CMD_CLASSIFY)
               ? npc_pkg::OP_CLASSIFY : npc_pkg::OP_WRITE;
    job.slot = npc_pkg::PAL_AW'(in_i.entry_index);
    job.rgb  = '{red: in_i.red, green: in_i.green, blue: in_i.blue};
  end

  assign push = accept && ((job.op == npc_pkg::OP_CLASSIFY) || in_range);
  assign pop  = job_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= job;
    end
  end

  assign jobq_o.valid = (count_q != '0);
  assign jobq_o.job   = fifo_q[rd_ptr_q];

endmodule

/* rtl/npc_back.sv */
// Back end: palette storage, entry-per-cycle distance search, result register.
// Uses npc_pkg; takes jobs from npc_front.
module npc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [npc_pkg::CFG_W-1:0]       cfg_data_i,
  input  npc_pkg::npc_jobq_t              jobq_i,
  output logic                            job_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output npc_pkg::npc_out_t               out_o
);

  function automatic logic [2*npc_pkg::CH_W-1:0] sq_diff(
    input logic [npc_pkg::CH_W-1:0] a,
    input logic [npc_pkg::CH_W-1:0] b
  );
    logic [npc_pkg::CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return (2*npc_pkg::CH_W)'(d) * (2*npc_pkg::CH_W)'(d);
  endfunction

  npc_pkg::npc_rgb_t               palette_q [npc_pkg::NUM_COLORS];
  logic [npc_pkg::CFG_W-1:0]       colors_q;
  npc_pkg::npc_state_e             state_q, state_d;
  logic [npc_pkg::PAL_AW-1:0]      cnt_q, cnt_d;
  logic [npc_pkg::PAL_AW-1:0]      last_q, last_d;
  npc_pkg::npc_rgb_t               sample_q, sample_d;
  logic [npc_pkg::IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [npc_pkg::DIST_W-1:0]      best_dist_q, best_dist_d;
  logic                            out_valid_q, out_valid_d;
  npc_pkg::npc_out_t               out_q, out_d;
  logic [npc_pkg::CFG_W-1:0]       search_n;
  npc_pkg::npc_rgb_t               entry;
  logic [npc_pkg::DIST_W-1:0]      entry_dist;
  logic                            take;
  logic [npc_pkg::IDX_W-1:0]       cand_idx;
  logic [npc_pkg::DIST_W-1:0]      cand_dist;
  logic                            out_free;
  logic                            pal_we;

  // Clamp the entry count to 1 .. SEARCH_MAX
  always_comb begin
    priority if (colors_q == '0) begin
      search_n = npc_pkg::CFG_W'(1);
    end else if (colors_q > npc_pkg::CFG_W'(npc_pkg::SEARCH_MAX)) begin
      search_n = npc_pkg::CFG_W'(npc_pkg::SEARCH_MAX);
    end else begin
      search_n = colors_q;
    end
  end

  assign entry      = palette_q[cnt_q];
  assign entry_dist = npc_pkg::DIST_W'(sq_diff(sample_q.red, entry.red))
                    + npc_pkg::DIST_W'(sq_diff(sample_q.green, entry.green))
                    + npc_pkg::DIST_W'(sq_diff(sample_q.blue, entry.blue));
  // Strict compare keeps the lowest index on ties
  assign take      = (cnt_q == '0) || (entry_dist < best_dist_q);
  assign cand_idx  = take ? npc_pkg::IDX_W'(cnt_q) : best_idx_q;
  assign cand_dist = take ? entry_dist : best_dist_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    sample_d    = sample_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    job_pop_o   = 1'b0;
    pal_we      = 1'b0;
    unique case (state_q)
      npc_pkg::ST_IDLE: begin
        if (jobq_i.valid) begin
          job_pop_o = 1'b1;
          if (jobq_i.job.op == npc_pkg::OP_WRITE) begin
            pal_we = 1'b1;
          end else begin
            sample_d = jobq_i.job.rgb;
            cnt_d    = '0;
            last_d   = npc_pkg::PAL_AW'(search_n - 1'b1);
            state_d  = npc_pkg::ST_SCAN;
          end
        end
      end
      npc_pkg::ST_SCAN: begin
        best_idx_d  = cand_idx;
        best_dist_d = cand_dist;
        if (cnt_q == last_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{nearest_index: cand_idx, nearest_squared_distance: cand_dist};
            state_d     = npc_pkg::ST_IDLE;
          end else begin
            state_d = npc_pkg::ST_HOLD;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      npc_pkg::ST_HOLD: begin
        // Wait for the result register to drain
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{nearest_index: best_idx_q, nearest_squared_distance: best_dist_q};
          state_d     = npc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = npc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      colors_q    <= npc_pkg::COLORS_IN_USE_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        colors_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    last_q      <= last_d;
    sample_q    <= sample_d;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    out_q       <= out_d;
  end

  // Palette clears to black at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < npc_pkg::NUM_COLORS; i++) begin
        palette_q[i] <= '0;
      end
    end else if (pal_we) begin
      palette_q[jobq_i.job.slot] <= jobq_i.job.rgb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
